[rtl/core/lru_pkg.sv]
// Shared constants and types for the LRU page replacement unit.
package lru_pkg;

  localparam int unsigned MAX_FRAMES_DEF = 16;
  localparam int unsigned PAGE_BITS_DEF  = 16;

  localparam int unsigned FRAMES_W   = 5;
  localparam logic [FRAMES_W-1:0] FRAMES_RST = 5'd16;

  localparam int unsigned COUNT_W = 16;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // Word index of each configuration register
  localparam logic [APB_AW-3:0] REG_FRAMES_IN_USE = '0;

  // Per-beat command broadcast along the cell row
  typedef struct packed {
    logic load;   // a reference beat is accepted this cycle
    logic flush;  // that beat ends the reference string
  } lru_cmd_t;

endpackage

[rtl/core/lru_in_if.sv]
// Reference channel: one page reference per beat.
interface lru_in_if
  import lru_pkg::*;
#(
  parameter int unsigned PAGE_BITS = PAGE_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page_number;
  logic                 last_ref;

  modport source (output valid, page_number, last_ref, input ready);
  modport sink   (input valid, page_number, last_ref, output ready);
endinterface

[rtl/core/lru_out_if.sv]
// Result channel: fault, eviction and running fault count per beat.
interface lru_out_if
  import lru_pkg::*;
#(
  parameter int unsigned PAGE_BITS = PAGE_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic                 fault;
  logic                 evict_valid;
  logic [PAGE_BITS-1:0] evicted_page;
  logic [COUNT_W-1:0]   fault_count;
  logic                 is_last;

  modport source (output valid, fault, evict_valid, evicted_page, fault_count, is_last,
                  input ready);
  modport sink   (input valid, fault, evict_valid, evicted_page, fault_count, is_last,
                  output ready);
endinterface

[rtl/core/lru_page_replacement_unit.sv]
// LRU page replacement unit: top level with config register, fault count and result register.
//
// Each beat on req_i is one page reference; each produces exactly one result beat on rsp_o.
// For each reference, all stack cells compare the page in parallel, a hit flag ripples
// down the cell row, and every cell shifts or holds at the same edge, so references are
// accepted back to back at one per cycle. The result sits in an output register; a new
// reference is taken whenever that register is empty or being drained. frames_in_use
// (byte address 0) sets capacity; 0 acts as 1 and values above MAX_FRAMES act as
// MAX_FRAMES. A reference with last_ref set clears the stack and fault count after its
// result is formed. No clearing pass is needed after reset.
module lru_page_replacement_unit
  import lru_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int unsigned PAGE_BITS  = PAGE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  lru_in_if.sink            req_i,
  lru_out_if.source         rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned CAP_W = $clog2(MAX_FRAMES + 1);

  logic [FRAMES_W-1:0]  frames_q;
  logic [CAP_W-1:0]     cap;
  logic [COUNT_W-1:0]   count_q, count_d, count_inc;
  logic                 accept;
  logic                 reg_sel;
  lru_cmd_t             cmd;
  logic                 hit;
  logic                 evict_valid;
  logic [PAGE_BITS-1:0] evicted_page;

  logic                 out_valid_q;
  logic                 fault_q;
  logic                 evict_valid_q;
  logic [PAGE_BITS-1:0] evicted_page_q;
  logic [COUNT_W-1:0]   fault_count_q;
  logic                 is_last_q;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = paddr[APB_AW-1:2] == REG_FRAMES_IN_USE;
  assign prdata  = reg_sel ? APB_DW'(frames_q) : '0;

  always_comb begin
    if (frames_q == '0) begin
      cap = CAP_W'(1);
    end else if (32'(frames_q) > MAX_FRAMES) begin
      cap = CAP_W'(MAX_FRAMES);
    end else begin
      cap = CAP_W'(frames_q);
    end
  end

  // handshake
  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign cmd.load    = accept;
  assign cmd.flush   = req_i.last_ref;

  lru_chain #(
    .MAX_FRAMES(MAX_FRAMES),
    .PAGE_BITS (PAGE_BITS),
    .CAP_W     (CAP_W)
  ) u_chain (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cap_i         (cap),
    .ref_page_i    (req_i.page_number),
    .hit_o         (hit),
    .evict_valid_o (evict_valid),
    .evicted_page_o(evicted_page)
  );

  // saturating fault count
  assign count_inc = (!hit && count_q != '1) ? count_q + COUNT_W'(1) : count_q;
  assign count_d   = req_i.last_ref ? '0 : count_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q    <= FRAMES_RST;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite && reg_sel) begin
        frames_q <= pwdata[FRAMES_W-1:0];
      end
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register, loaded with each accepted beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fault_q        <= ~hit;
      evict_valid_q  <= evict_valid;
      evicted_page_q <= evicted_page;
      fault_count_q  <= count_inc;
      is_last_q      <= req_i.last_ref;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.fault        = fault_q;
  assign rsp_o.evict_valid  = evict_valid_q;
  assign rsp_o.evicted_page = evicted_page_q;
  assign rsp_o.fault_count  = fault_count_q;
  assign rsp_o.is_last      = is_last_q;

endmodule

[rtl/core/lru_cell.sv]
// One slot of the LRU stack: holds a page, compares and shifts from its upper neighbour.
module lru_cell
  import lru_pkg::*;
#(
  parameter int unsigned IDX       = 0,
  parameter int unsigned PAGE_BITS = PAGE_BITS_DEF,
  parameter int unsigned CAP_W     = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lru_cmd_t             cmd_i,
  input  logic                 fault_i,
  input  logic [CAP_W-1:0]     cap_i,
  input  logic [PAGE_BITS-1:0] ref_page_i,
  input  logic [PAGE_BITS-1:0] up_page_i,
  input  logic                 up_valid_i,
  input  logic                 seen_i,
  output logic [PAGE_BITS-1:0] page_o,
  output logic                 valid_o,
  output logic                 seen_o,
  output logic                 evict_o,
  output logic [PAGE_BITS-1:0] evict_page_o
);

  logic [PAGE_BITS-1:0] page_q, page_d;
  logic                 valid_q, valid_d;
  logic                 match;
  logic                 in_cap;
  logic                 cap_slot;

  assign match    = valid_q && (page_q == ref_page_i);
  assign in_cap   = cap_i > CAP_W'(IDX);
  assign cap_slot = cap_i == CAP_W'(IDX + 1);

  assign seen_o       = seen_i | match;
  assign evict_o      = valid_q & cap_slot;
  assign evict_page_o = evict_o ? page_q : '0;
  assign page_o       = page_q;
  assign valid_o      = valid_q;

  always_comb begin
    page_d  = page_q;
    valid_d = valid_q;
    if (cmd_i.load) begin
      if (fault_i) begin
        // push: slots inside capacity shift down, the rest drop out
        if (in_cap) begin
          page_d  = up_page_i;
          valid_d = up_valid_i;
        end else begin
          valid_d = 1'b0;
        end
      end else if (!seen_i) begin
        // hit further down: shift down to close the gap
        page_d  = up_page_i;
        valid_d = up_valid_i;
      end
      if (cmd_i.flush) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

endmodule

[rtl/core/lru_chain.sv]
// Row of stack cells with the hit chain and the eviction read-out.
module lru_chain
  import lru_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int unsigned PAGE_BITS  = PAGE_BITS_DEF,
  parameter int unsigned CAP_W      = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lru_cmd_t             cmd_i,
  input  logic [CAP_W-1:0]     cap_i,
  input  logic [PAGE_BITS-1:0] ref_page_i,
  output logic                 hit_o,
  output logic                 evict_valid_o,
  output logic [PAGE_BITS-1:0] evicted_page_o
);

  logic [PAGE_BITS-1:0] page   [MAX_FRAMES+1];
  logic                 valid  [MAX_FRAMES+1];
  logic                 seen   [MAX_FRAMES+1];
  logic [PAGE_BITS-1:0] ev_page[MAX_FRAMES];
  logic                 ev     [MAX_FRAMES];
  logic                 fault;

  // top slot is fed by the referenced page itself
  assign page[0]  = ref_page_i;
  assign valid[0] = 1'b1;
  assign seen[0]  = 1'b0;

  assign hit_o = seen[MAX_FRAMES];
  assign fault = ~seen[MAX_FRAMES];

  for (genvar k = 0; k < MAX_FRAMES; k++) begin : g_cell
    lru_cell #(
      .IDX      (k),
      .PAGE_BITS(PAGE_BITS),
      .CAP_W    (CAP_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd_i),
      .fault_i     (fault),
      .cap_i       (cap_i),
      .ref_page_i  (ref_page_i),
      .up_page_i   (page[k]),
      .up_valid_i  (valid[k]),
      .seen_i      (seen[k]),
      .page_o      (page[k+1]),
      .valid_o     (valid[k+1]),
      .seen_o      (seen[k+1]),
      .evict_o     (ev[k]),
      .evict_page_o(ev_page[k])
    );
  end

  // only the slot at capacity-1 drives a non-zero page
  always_comb begin
    evict_valid_o  = 1'b0;
    evicted_page_o = '0;
    for (int k = 0; k < MAX_FRAMES; k++) begin
      evict_valid_o  = evict_valid_o | ev[k];
      evicted_page_o = evicted_page_o | ev_page[k];
    end
    evict_valid_o = evict_valid_o & fault;
    if (!fault) begin
      evicted_page_o = '0;
    end
  end

endmodule

[dv/lru_page_replacement_unit_test.sv]
// Self-checking testbench for the LRU page replacement unit.
`timescale 1ns / 1ps

module lru_page_replacement_unit_test;
  import lru_pkg::*;

  typedef struct packed {
    logic        fault;
    logic        evict_valid;
    logic [15:0] evicted_page;
    logic [15:0] fault_count;
    logic        is_last;
  } ref_outcome_t;

  // Tracks the LRU stack and the fault count, and holds the outcomes still owed by the unit.
  class lru_stack_scoreboard;
    logic [15:0]  stack_page [16];
    int unsigned  resident   = 0;
    logic [15:0]  fault_tally = '0;
    logic [4:0]   frames_reg = FRAMES_RST;
    ref_outcome_t pending_outcomes [$];
    int unsigned  mismatches = 0;

    function int unsigned capacity();
      if (frames_reg == 0) return 1;
      if (frames_reg > 16) return 16;
      return frames_reg;
    endfunction

    function void note_reference(logic [15:0] page, logic last);
      ref_outcome_t o;
      int unsigned  hit_at;
      int unsigned  cap;
      o      = '0;
      hit_at = resident;
      for (int i = resident - 1; i >= 0; i--)
        if (stack_page[i] == page) hit_at = i;
      if (hit_at < resident) begin
        for (int k = hit_at; k > 0; k--) stack_page[k] = stack_page[k-1];
        stack_page[0] = page;
      end else begin
        cap     = capacity();
        o.fault = 1'b1;
        if (resident >= cap) begin
          o.evict_valid  = 1'b1;
          o.evicted_page = stack_page[cap-1];
          resident       = cap - 1;
        end
        for (int k = resident; k > 0; k--) stack_page[k] = stack_page[k-1];
        stack_page[0] = page;
        resident++;
        if (fault_tally != 16'hFFFF) fault_tally++;
      end
      o.fault_count = fault_tally;
      o.is_last     = last;
      pending_outcomes.push_back(o);
      // the string ends: drop every page and the count
      if (last) begin
        resident    = 0;
        fault_tally = '0;
      end
    endfunction

    function void report(string what, logic [15:0] exp_val, logic [15:0] got_val);
      mismatches++;
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, what, exp_val, got_val);
    endfunction

    function void check_result(ref_outcome_t got);
      ref_outcome_t exp_o;
      if (pending_outcomes.size() == 0) begin
        report("unexpected result beat, fault_count", '0, got.fault_count);
        return;
      end
      exp_o = pending_outcomes.pop_front();
      if (got.fault !== exp_o.fault) report("fault", 16'(exp_o.fault), 16'(got.fault));
      if (got.evict_valid !== exp_o.evict_valid)
        report("evict_valid", 16'(exp_o.evict_valid), 16'(got.evict_valid));
      if (got.evicted_page !== exp_o.evicted_page)
        report("evicted_page", exp_o.evicted_page, got.evicted_page);
      if (got.fault_count !== exp_o.fault_count)
        report("fault_count", exp_o.fault_count, got.fault_count);
      if (got.is_last !== exp_o.is_last)
        report("is_last", 16'(exp_o.is_last), 16'(got.is_last));
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              steady;

  lru_in_if  #(.PAGE_BITS(16)) req_if ();
  lru_out_if #(.PAGE_BITS(16)) rsp_if ();

  lru_stack_scoreboard stack_sb;

  lru_page_replacement_unit #(
    .MAX_FRAMES(16),
    .PAGE_BITS (16)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Result side: check each beat, then stall at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready)
        stack_sb.check_result({rsp_if.fault, rsp_if.evict_valid, rsp_if.evicted_page,
                               rsp_if.fault_count, rsp_if.is_last});
      rsp_if.ready <= steady || ($urandom_range(99) >= 23);
    end
  end

  task automatic send_reference(input logic [15:0] page, input logic last);
    while (!steady && $urandom_range(99) < 23) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.page_number <= page;
    req_if.last_ref    <= last;
    do @(posedge clk_i); while (!req_if.ready);
    stack_sb.note_reference(page, last);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (stack_sb.pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Write the frame count, then read it back.
  task automatic write_frames(input logic [4:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_FRAMES_IN_USE, 2'b00};
    pwdata  <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    stack_sb.frames_reg = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== APB_DW'(value))
      stack_sb.report("frames_in_use readback", 16'(value), prdata[15:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_string_mix(input int unsigned count);
    logic [15:0] pool [24];
    logic [15:0] base;
    int unsigned pool_len;
    logic [15:0] page;
    pool_len = stack_sb.capacity() + $urandom_range(0, 4);
    if (pool_len > 24) pool_len = 24;
    base = 16'($urandom);
    // sometimes pages that each differ from one base page in a single bit
    if ($urandom_range(9) < 3) begin
      foreach (pool[k]) pool[k] = base ^ (16'h1 << (k % 16));
    end else begin
      foreach (pool[k]) pool[k] = 16'($urandom);
    end
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 12) page = 16'($urandom);
      else page = pool[$urandom_range(pool_len - 1)];
      send_reference(page, $urandom_range(59) == 0);
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned count;
    logic [4:0]  frames;

    stack_sb           = new;
    steady             = 1'b0;
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    req_if.valid       = 1'b0;
    req_if.page_number = '0;
    req_if.last_ref    = 1'b0;
    rsp_if.ready       = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset frame count: extremes of the page number, a hit, end of string
    send_reference(16'h0000, 1'b0);
    send_reference(16'hFFFF, 1'b0);
    send_reference(16'h0000, 1'b0);
    send_reference(16'h5A5A, 1'b1);
    drain();

    // zero frames behaves as one
    write_frames(5'd0);
    send_reference(16'h0007, 1'b0);
    send_reference(16'h0008, 1'b0);
    send_reference(16'h0007, 1'b0);
    drain();

    // oversized frame count behaves as the maximum: fill, then evict the oldest
    write_frames(5'd31);
    for (int i = 0; i <= 16; i++) send_reference(16'h0100 + 16'(i), 1'b0);
    drain();

    // shrink while full: a deep page still hits, the next fault cuts the stack
    write_frames(5'd3);
    send_reference(16'h0105, 1'b0);
    send_reference(16'hA5A5, 1'b0);
    send_reference(16'hA5A5, 1'b1);
    drain();

    sent  = 0;
    phase = 0;
    while (sent < 1950) begin
      case ($urandom_range(5))
        0:       frames = 5'd0;
        1:       frames = 5'd1;
        2:       frames = 5'd16;
        3:       frames = 5'($urandom_range(17, 31));
        default: frames = 5'($urandom_range(1, 16));
      endcase
      write_frames(frames);
      steady = (phase == 6);
      count  = $urandom_range(20, 120);
      run_string_mix(count);
      sent  += count;
      phase++;
      drain();
    end
    steady = 1'b0;

    repeat (4) @(posedge clk_i);
    if (stack_sb.mismatches == 0 && stack_sb.pending_outcomes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

endmodule
